@@ rtl/core/uule_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uule_pkg
// Shared constants, command/status types and the character map of the
// uuencode line encoder.
// ----------------------------------------------------------------------------
package uule_pkg;

  // Bytes in one full line and the widths that follow from it
  localparam int LINE_BYTES = 45;
  localparam int CNT_W      = 6;
  localparam int ADDR_W     = 6;

  // Character source codes
  localparam logic [2:0] CH_LEN = 3'd0;
  localparam logic [2:0] CH_G0  = 3'd1;
  localparam logic [2:0] CH_G1  = 3'd2;
  localparam logic [2:0] CH_G2  = 3'd3;
  localparam logic [2:0] CH_G3  = 3'd4;
  localparam logic [2:0] CH_NL  = 3'd5;
  localparam logic [2:0] CH_BT  = 3'd6;

  localparam logic [6:0] ASCII_NL = 7'h0A;
  localparam logic [6:0] ASCII_BT = 7'h60;
  localparam logic [6:0] ASCII_SP = 7'h20;

  // Controller to datapath
  typedef struct packed {
    logic       accept;
    logic       load;
    logic       last;
    logic [2:0] char_sel;
    logic       clr_count;
    logic       base_clr;
    logic       base_adv;
    logic       rd_en;
    logic [1:0] rd_off;
    logic       cap_en;
    logic [1:0] cap_idx;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic line_full;
    logic pend_nz;
    logic load_ok;
    logic more;
  } stat_t;

  // Map six bits to a printable character, zero going to backtick
  function automatic logic [6:0] enc6(input logic [5:0] v);
    logic [6:0] c;
    c = (v == 6'd0) ? ASCII_BT : ({1'b0, v} + ASCII_SP);
    return c;
  endfunction

endpackage

@@ rtl/core/uule_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uule_ctrl
// Sequencer: takes input transactions, then steps through length character,
// byte groups, newline and terminator line.
// ----------------------------------------------------------------------------
module uule_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            end_of_data,
  input  uule_pkg::stat_t st,
  output uule_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LEN  = 4'd1;
  localparam logic [3:0] S_RD0  = 4'd2;
  localparam logic [3:0] S_RD1  = 4'd3;
  localparam logic [3:0] S_RD2  = 4'd4;
  localparam logic [3:0] S_RD3  = 4'd5;
  localparam logic [3:0] S_CH0  = 4'd6;
  localparam logic [3:0] S_CH1  = 4'd7;
  localparam logic [3:0] S_CH2  = 4'd8;
  localparam logic [3:0] S_CH3  = 4'd9;
  localparam logic [3:0] S_NL   = 4'd10;
  localparam logic [3:0] S_TB   = 4'd11;
  localparam logic [3:0] S_TN   = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       term;
  logic       term_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next   = state;
    term_next    = term;
    cmd          = '0;
    cmd.accept   = in_valid && (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (cmd.accept) begin
          term_next = end_of_data;
          if (st.line_full || (end_of_data && st.pend_nz)) begin
            state_next = S_LEN;
          end else if (end_of_data) begin
            state_next = S_TB;
          end
        end
      end
      S_LEN: begin
        cmd.char_sel = uule_pkg::CH_LEN;
        if (st.load_ok) begin
          cmd.load     = 1'b1;
          cmd.base_clr = 1'b1;
          state_next   = S_RD0;
        end
      end
      S_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_off = 2'd0;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_idx = 2'd0;
        cmd.rd_en   = 1'b1;
        cmd.rd_off  = 2'd1;
        state_next  = S_RD2;
      end
      S_RD2: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_idx = 2'd1;
        cmd.rd_en   = 1'b1;
        cmd.rd_off  = 2'd2;
        state_next  = S_RD3;
      end
      S_RD3: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_idx = 2'd2;
        state_next  = S_CH0;
      end
      S_CH0: begin
        cmd.char_sel = uule_pkg::CH_G0;
        if (st.load_ok) begin
          cmd.load   = 1'b1;
          state_next = S_CH1;
        end
      end
      S_CH1: begin
        cmd.char_sel = uule_pkg::CH_G1;
        if (st.load_ok) begin
          cmd.load   = 1'b1;
          state_next = S_CH2;
        end
      end
      S_CH2: begin
        cmd.char_sel = uule_pkg::CH_G2;
        if (st.load_ok) begin
          cmd.load   = 1'b1;
          state_next = S_CH3;
        end
      end
      S_CH3: begin
        cmd.char_sel = uule_pkg::CH_G3;
        if (st.load_ok) begin
          cmd.load     = 1'b1;
          cmd.base_adv = 1'b1;
          state_next   = st.more ? S_RD0 : S_NL;
        end
      end
      S_NL: begin
        cmd.char_sel = uule_pkg::CH_NL;
        cmd.last     = !term;
        if (st.load_ok) begin
          cmd.load      = 1'b1;
          cmd.clr_count = 1'b1;
          state_next    = term ? S_TB : S_IDLE;
        end
      end
      S_TB: begin
        cmd.char_sel = uule_pkg::CH_BT;
        if (st.load_ok) begin
          cmd.load   = 1'b1;
          state_next = S_TN;
        end
      end
      S_TN: begin
        cmd.char_sel = uule_pkg::CH_NL;
        cmd.last     = 1'b1;
        if (st.load_ok) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and the pending terminator flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      term  <= 1'b0;
    end else begin
      state <= state_next;
      term  <= term_next;
    end
  end

endmodule

@@ rtl/core/uule_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uule_dpath
// Line buffer, byte count, group registers, character map and the output
// register of the uuencode line encoder.
// ----------------------------------------------------------------------------
module uule_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [7:0]                     data_byte,
  input  logic                           has_byte,
  input  uule_pkg::cmd_t                 cmd,
  output uule_pkg::stat_t                st,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [6:0]                     out_char,
  output logic                           last_of_run
);

  logic [7:0]                  mem [uule_pkg::LINE_BYTES];
  logic [uule_pkg::CNT_W-1:0]  count;
  logic [uule_pkg::CNT_W-1:0]  count_after;
  logic [uule_pkg::ADDR_W-1:0] base;
  logic [uule_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]                  rd_data;
  logic                        rd_hit;
  logic [7:0]                  cap_byte;
  logic [7:0]                  grp_a;
  logic [7:0]                  grp_b;
  logic [7:0]                  grp_c;
  logic [6:0]                  char_next;

  assign count_after = count + {{(uule_pkg::CNT_W-1){1'b0}}, has_byte};
  assign rd_addr     = base + {{(uule_pkg::ADDR_W-2){1'b0}}, cmd.rd_off};

  // Status for the sequencer
  assign st.line_full = has_byte && (count_after == uule_pkg::CNT_W'(uule_pkg::LINE_BYTES));
  assign st.pend_nz   = (count_after != '0);
  assign st.load_ok   = !out_valid || out_ready;
  assign st.more      = ({1'b0, base} + 7'd3) < {1'b0, count};

  // Store an incoming byte; read one entry per cycle
  always_ff @(posedge clk) begin
    if (cmd.accept && has_byte) begin
      mem[count] <= data_byte;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
      rd_hit  <= ({1'b0, rd_addr} < {1'b0, count});
    end
  end

  // Advance the byte count and the group base
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      base  <= '0;
    end else begin
      if (cmd.clr_count) begin
        count <= '0;
      end else if (cmd.accept) begin
        count <= count_after;
      end
      if (cmd.base_clr) begin
        base <= '0;
      end else if (cmd.base_adv) begin
        base <= base + uule_pkg::ADDR_W'(3);
      end
    end
  end

  // Capture group bytes, padding past the line end with zero
  assign cap_byte = rd_hit ? rd_data : 8'h00;

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      unique case (cmd.cap_idx)
        2'd0:    grp_a <= cap_byte;
        2'd1:    grp_b <= cap_byte;
        default: grp_c <= cap_byte;
      endcase
    end
  end

  // Pick the next character
  always_comb begin
    unique case (cmd.char_sel)
      uule_pkg::CH_LEN: char_next = uule_pkg::enc6(count);
      uule_pkg::CH_G0:  char_next = uule_pkg::enc6(grp_a[7:2]);
      uule_pkg::CH_G1:  char_next = uule_pkg::enc6({grp_a[1:0], grp_b[7:4]});
      uule_pkg::CH_G2:  char_next = uule_pkg::enc6({grp_b[3:0], grp_c[7:6]});
      uule_pkg::CH_G3:  char_next = uule_pkg::enc6(grp_c[5:0]);
      uule_pkg::CH_BT:  char_next = uule_pkg::ASCII_BT;
      default:          char_next = uule_pkg::ASCII_NL;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_char    <= char_next;
      last_of_run <= cmd.last;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= uule_pkg::CNT_W'(uule_pkg::LINE_BYTES))
    else $error("byte count beyond line length");

  a_load_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> ({1'b0, rd_addr} < 7'(uule_pkg::LINE_BYTES)))
    else $error("buffer read out of range");

  a_cap_after_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.cap_en |-> $past(cmd.rd_en))
    else $error("group capture without a read");

endmodule

@@ rtl/core/uuencode_line_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uuencode_line_encoder
// Collects raw bytes into lines of up to 45 and sends each line uuencoded,
// one character per transaction, followed by a terminator line at end of data.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  input    in_valid/in_ready    data_byte, has_byte, end_of_data
//  output   out_valid/out_ready  out_char, last_of_run
//
//  An input transaction that only stores a byte leaves the sequencer idle.
//  A line of n bytes is sent as a length character, ceil(n/3) groups and a
//  newline: the single buffer read port fetches each 3-byte group in states
//  RD0 to RD3 and the output register then carries its four characters, one
//  per cycle. The terminator line is a backtick and a newline. Stalls on
//  out_ready hold the sequence. Reset (rst, synchronous) clears the count,
//  sequencer and output valid; the line buffer is not cleared.
// ----------------------------------------------------------------------------
module uuencode_line_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       has_byte,
  input  logic       end_of_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       last_of_run
);

  uule_pkg::cmd_t  cmd;
  uule_pkg::stat_t st;

  // Sequencer
  uule_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .end_of_data (end_of_data),
    .st          (st),
    .cmd         (cmd)
  );

  // Buffer and character datapath
  uule_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .has_byte    (has_byte),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .last_of_run (last_of_run)
  );

endmodule
